// ===== hw/rtl/bwtg_pkg.sv =====
// Shared types, codes and constants of the blend weight table generator.
package bwtg_pkg;

  // Shape modes
  localparam logic [3:0] MODE_EQUAL = 4'd0;
  localparam logic [3:0] MODE_ASC   = 4'd1;
  localparam logic [3:0] MODE_DESC  = 4'd2;
  localparam logic [3:0] MODE_PYR   = 4'd3;
  localparam logic [3:0] MODE_GAUSS = 4'd4;
  localparam logic [3:0] MODE_GREV  = 4'd5;
  localparam logic [3:0] MODE_GSYM  = 4'd6;
  localparam logic [3:0] MODE_VEGAS = 4'd7;
  localparam logic [3:0] MODE_CUST  = 4'd8;

  // Input commands
  localparam logic [1:0] CMD_APPEND = 2'd0;
  localparam logic [1:0] CMD_CLEAR  = 2'd1;
  localparam logic [1:0] CMD_GEN    = 2'd2;

  // Configuration register indexes
  localparam logic [2:0] CFG_MODE   = 3'd0;
  localparam logic [2:0] CFG_FRAMES = 3'd1;
  localparam logic [2:0] CFG_MEAN   = 3'd2;
  localparam logic [2:0] CFG_SPREAD = 3'd3;
  localparam logic [2:0] CFG_BLOW   = 3'd4;
  localparam logic [2:0] CFG_BHIGH  = 3'd5;

  // Reset values of the configuration registers
  localparam logic [6:0]  RST_FRAMES = 7'd30;
  localparam logic [14:0] RST_SPREAD = 15'd256;
  localparam logic [15:0] RST_BLOW   = 16'hFE00;
  localparam logic [15:0] RST_BHIGH  = 16'h0200;

  // log2(e) in Q16
  localparam logic [16:0] LOG2E_Q16 = 17'd94548;

  // Divider widths: dividend, divisor, quotient
  localparam int unsigned DIV_NW = 64;
  localparam int unsigned DIV_DW = 48;
  localparam int unsigned DIV_QW = 17;

  typedef enum logic [4:0] {
    OP_IDLE, OP_ACCEPT, OP_SETUP0, OP_SETUP1, OP_SETUP2,
    OP_F_SQ, OP_F_DIV, OP_F_EXP, OP_F_INT, OP_F_WR,
    OP_S_RD, OP_S_ACC, OP_O_RD, OP_O_DIV, OP_O_LOAD, OP_ERR_LOAD, OP_O_NEXT
  } bwtg_op_e;

  typedef enum logic [4:0] {
    ST_IDLE, ST_SETUP0, ST_SETUP1, ST_SETUP2,
    ST_F_SQ, ST_F_DIV, ST_F_WAIT, ST_F_EXP, ST_F_INT, ST_F_WR,
    ST_S_RD, ST_S_ACC, ST_O_RD, ST_O_DIV, ST_O_WAIT, ST_O_HOLD, ST_ERR
  } bwtg_state_e;

  typedef struct packed {
    bwtg_op_e op;
  } bwtg_cmd_t;

  typedef struct packed {
    logic is_last;
    logic err;
    logic div_done;
    logic out_last;
  } bwtg_status_t;

  // 2^(-k/16) in Q16, k = 0..16
  function automatic logic [16:0] pow2_frac(input logic [4:0] k);
    logic [16:0] v;
    case (k)
      5'd0:  v = 17'd65536;
      5'd1:  v = 17'd62757;
      5'd2:  v = 17'd60097;
      5'd3:  v = 17'd57549;
      5'd4:  v = 17'd55109;
      5'd5:  v = 17'd52773;
      5'd6:  v = 17'd50535;
      5'd7:  v = 17'd48393;
      5'd8:  v = 17'd46341;
      5'd9:  v = 17'd44376;
      5'd10: v = 17'd42495;
      5'd11: v = 17'd40693;
      5'd12: v = 17'd38968;
      5'd13: v = 17'd37316;
      5'd14: v = 17'd35734;
      5'd15: v = 17'd34219;
      default: v = 17'd32768;
    endcase
    return v;
  endfunction

endpackage

// ===== hw/rtl/bwtg_ram.sv =====
// Generic simple dual-port RAM with registered read.
module bwtg_ram #(
  parameter int unsigned WIDTH = 16,
  parameter int unsigned DEPTH = 64,
  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port and registered read port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_o <= mem[raddr_i];
  end

endmodule

// ===== hw/rtl/bwtg_div.sv =====
// Restoring divider, one quotient bit per cycle, 17-bit quotient.
module bwtg_div (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  logic                                  start_i,
  input  logic [bwtg_pkg::DIV_NW-1:0]           num_i,
  input  logic [bwtg_pkg::DIV_DW-1:0]           den_i,
  output logic                                  done_o,
  output logic [bwtg_pkg::DIV_QW-1:0]           quot_o
);
  import bwtg_pkg::*;

  localparam int unsigned CNTW = $clog2(DIV_QW + 1);

  logic [DIV_NW-1:0] rem_q, rem_d;
  logic [DIV_NW-1:0] dsh_q, dsh_d;
  logic [DIV_QW-1:0] quot_q, quot_d;
  logic [CNTW-1:0]   cnt_q, cnt_d;
  logic              busy_q, busy_d;
  logic              done_q, done_d;

  // one compare and subtract per step
  always_comb begin
    rem_d  = rem_q;
    dsh_d  = dsh_q;
    quot_d = quot_q;
    cnt_d  = cnt_q;
    busy_d = busy_q;
    done_d = 1'b0;
    if (start_i) begin
      rem_d  = num_i;
      dsh_d  = DIV_NW'({den_i, 16'd0});
      quot_d = '0;
      cnt_d  = CNTW'(DIV_QW);
      busy_d = 1'b1;
    end else if (busy_q) begin
      if (rem_q >= dsh_q) begin
        rem_d  = rem_q - dsh_q;
        quot_d = {quot_q[DIV_QW-2:0], 1'b1};
      end else begin
        quot_d = {quot_q[DIV_QW-2:0], 1'b0};
      end
      dsh_d = dsh_q >> 1;
      cnt_d = cnt_q - 1'b1;
      if (cnt_q == CNTW'(1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q  <= rem_d;
    dsh_q  <= dsh_d;
    quot_q <= quot_d;
  end

  assign done_o = done_q;
  assign quot_o = quot_q;

endmodule

// ===== hw/rtl/bwtg_dp.sv =====
// Datapath: configuration, custom store, raw buffer, gaussian and normalize math.
module bwtg_dp #(
  parameter int unsigned MAX_FRAMES = 64,
  parameter int unsigned MAX_CUSTOM = 64
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   cfg_we_i,
  input  logic [2:0]             cfg_idx_i,
  input  logic [15:0]            cfg_data_i,
  input  logic [1:0]             command_i,
  input  logic [15:0]            custom_weight_i,
  input  bwtg_pkg::bwtg_cmd_t    cmd_i,
  output bwtg_pkg::bwtg_status_t status_o,
  output logic [15:0]            weight_o,
  output logic [5:0]             position_o,
  output logic                   last_o,
  output logic                   error_o
);
  import bwtg_pkg::*;

  localparam int unsigned IW   = $clog2(MAX_FRAMES);
  localparam int unsigned NW   = $clog2(MAX_FRAMES + 1);
  localparam int unsigned CAW  = (MAX_CUSTOM > 1) ? $clog2(MAX_CUSTOM) : 1;
  localparam int unsigned CW   = $clog2(MAX_CUSTOM + 1);
  localparam int unsigned DW   = 20 + IW;
  localparam int unsigned SW   = 2 * DW;
  localparam int unsigned DENW = 31 + 2 * IW;
  localparam int unsigned TW   = 32 + IW;

  // configuration registers
  logic [3:0]  mode_q;
  logic [6:0]  frames_q;
  logic [15:0] mean_q;
  logic [14:0] spread_q;
  logic [15:0] blow_q;
  logic [15:0] bhigh_q;

  // custom list
  logic [CW-1:0]  ccount_q;
  logic           cram_we;
  logic [CAW-1:0] cram_raddr;
  logic [15:0]    cram_rdata;

  // run state
  logic [NW-1:0]        n_q;
  logic [IW-1:0]        mm_q;
  logic [IW-1:0]        idx_q;
  logic [3:0]           kind_q;
  logic                 err_q, gauss_q, rev_q, cust_q;
  logic signed [17:0]   glo_q, ghi_q, gmean_q;
  logic [29:0]          s2_q;
  logic [2*IW-1:0]      mm2_q;
  logic signed [DW-1:0] diff0_q, d_q;
  logic signed [18:0]   step_q;
  logic [DENW-1:0]      den_q;
  logic [SW-1:0]        sq_q;
  logic [IW+CW+3:0]     cnum_q;
  logic                 sat_q;
  logic [17:0]          u_q;
  logic [16:0]          v_q;
  logic [4:0]           ip_q;
  logic signed [15:0]   picked_q;
  logic signed [15:0]   mn_q;
  logic [TW-1:0]        total_q;

  // output register
  logic [15:0] weight_q;
  logic [5:0]  pos_q;
  logic        olast_q, oerr_q;

  // raw buffer
  logic          rram_we;
  logic [IW-1:0] rram_raddr;
  logic [31:0]   rram_wdata, rram_rdata;

  // divider
  logic                div_start;
  logic [DIV_NW-1:0]   div_num;
  logic [DIV_DW-1:0]   div_den;
  logic                div_done;
  logic [DIV_QW-1:0]   div_quot;

  // setup helpers
  logic [NW-1:0]      n_calc;
  logic [3:0]         kind_calc;
  logic signed [17:0] blo_s, bhi_s, alo, ahi, mag;
  logic               err_calc;
  logic               is_last;
  logic [17:0]        adj;
  logic signed [33:0] reff;
  logic [DW-1:0]      ad;
  logic [16:0]        t12;
  logic [33:0]        uprod;
  logic [16:0]        pa, pb;
  logic [24:0]        ipl;
  logic [31:0]        shape;
  logic signed [IW+2:0] pyr_d;
  logic [CAW-1:0]     cidx;

  bwtg_ram #(.WIDTH(16), .DEPTH(MAX_CUSTOM)) u_cram (
    .clk_i   (clk_i),
    .we_i    (cram_we),
    .waddr_i (CAW'(ccount_q)),
    .wdata_i (custom_weight_i),
    .raddr_i (cram_raddr),
    .rdata_o (cram_rdata)
  );

  bwtg_ram #(.WIDTH(32), .DEPTH(MAX_FRAMES)) u_rram (
    .clk_i   (clk_i),
    .we_i    (rram_we),
    .waddr_i (idx_q),
    .wdata_i (rram_wdata),
    .raddr_i (rram_raddr),
    .rdata_o (rram_rdata)
  );

  bwtg_div u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_start),
    .num_i   (div_num),
    .den_i   (div_den),
    .done_o  (div_done),
    .quot_o  (div_quot)
  );

  // table length, shape kind and error check
  always_comb begin
    if (frames_q == 7'd0) begin
      n_calc = NW'(1);
    end else if (32'(frames_q) > 32'(MAX_FRAMES)) begin
      n_calc = NW'(MAX_FRAMES);
    end else begin
      n_calc = NW'(frames_q);
    end
    kind_calc = (mode_q > MODE_CUST) ? MODE_EQUAL : mode_q;
    blo_s = {{2{blow_q[15]}}, blow_q};
    bhi_s = {{2{bhigh_q[15]}}, bhigh_q};
    alo   = blo_s[17] ? -blo_s : blo_s;
    ahi   = bhi_s[17] ? -bhi_s : bhi_s;
    mag   = (alo > ahi) ? alo : ahi;
    err_calc = 1'b0;
    case (kind_calc)
      MODE_GAUSS, MODE_GREV: err_calc = (blow_q == bhigh_q);
      MODE_GSYM:             err_calc = (blow_q == 16'd0) && (bhigh_q == 16'd0);
      MODE_CUST:             err_calc = (ccount_q == '0);
      default:               err_calc = 1'b0;
    endcase
  end

  assign is_last = ({1'b0, idx_q} == NW'(n_q - 1'b1));
  assign adj     = (cust_q && mn_q < 0) ? (18'(-$signed({mn_q[15], mn_q})) + 18'd256) : 18'd0;
  assign reff    = $signed({{2{rram_rdata[31]}}, rram_rdata}) + $signed({16'd0, adj});
  assign ad      = d_q[DW-1] ? DW'(-d_q) : DW'(d_q);

  // exponent and interpolation helpers
  always_comb begin
    t12   = sat_q ? 17'h10000 : {1'b0, div_quot[15:0]};
    uprod = t12 * LOG2E_Q16;
    pa    = pow2_frac({1'b0, u_q[11:8]});
    pb    = pow2_frac(5'({1'b0, u_q[11:8]} + 5'd1));
    ipl   = 25'(pa - pb) * 25'(u_q[7:0]);
    cidx  = (32'(div_quot) >= 32'(ccount_q)) ? CAW'(ccount_q - 1'b1) : CAW'(div_quot);
  end

  // raw weight of the current entry
  always_comb begin
    pyr_d = $signed({2'b0, idx_q, 1'b0}) - $signed((IW+3)'(n_q - 1'b1));
    if (pyr_d < 0) begin
      pyr_d = -pyr_d;
    end
    case (kind_q)
      MODE_ASC:   shape = 32'(idx_q) + 32'd1;
      MODE_DESC:  shape = 32'(n_q) - 32'(idx_q);
      MODE_PYR:   shape = 32'(n_q) + 32'd1 - 32'(pyr_d);
      MODE_VEGAS: shape = (!n_q[0] && idx_q != '0 && !is_last) ? 32'd2 : 32'd1;
      MODE_GAUSS, MODE_GREV, MODE_GSYM:
                  shape = 32'(({14'd0, v_q} << 14) >> ip_q);
      MODE_CUST:  shape = 32'($signed(picked_q));
      default:    shape = 32'd1;
    endcase
  end

  // memory and divider control
  always_comb begin
    cram_we    = (cmd_i.op == OP_ACCEPT) && (command_i == CMD_APPEND) &&
                 (32'(ccount_q) < 32'(MAX_CUSTOM));
    cram_raddr = cidx;
    rram_we    = (cmd_i.op == OP_F_WR);
    rram_wdata = shape;
    rram_raddr = (cmd_i.op == OP_O_RD && rev_q) ? IW'(n_q - 1'b1 - NW'(idx_q)) : idx_q;
    div_start  = (cmd_i.op == OP_F_DIV) || (cmd_i.op == OP_O_DIV);
    if (cmd_i.op == OP_O_DIV) begin
      div_num = DIV_NW'(reff) << 16;
      div_den = DIV_DW'(total_q);
    end else if (gauss_q) begin
      div_num = DIV_NW'(sq_q) << 12;
      div_den = DIV_DW'(den_q);
    end else begin
      div_num = DIV_NW'(cnum_q);
      div_den = DIV_DW'(mm_q) * DIV_DW'(10);
    end
  end

  // configuration and custom count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q   <= MODE_EQUAL;
      frames_q <= RST_FRAMES;
      mean_q   <= '0;
      spread_q <= RST_SPREAD;
      blow_q   <= RST_BLOW;
      bhigh_q  <= RST_BHIGH;
      ccount_q <= '0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_idx_i)
          CFG_MODE:   mode_q   <= cfg_data_i[3:0];
          CFG_FRAMES: frames_q <= cfg_data_i[6:0];
          CFG_MEAN:   mean_q   <= cfg_data_i;
          CFG_SPREAD: spread_q <= cfg_data_i[14:0];
          CFG_BLOW:   blow_q   <= cfg_data_i;
          CFG_BHIGH:  bhigh_q  <= cfg_data_i;
          default: ;
        endcase
      end
      if (cram_we) begin
        ccount_q <= ccount_q + 1'b1;
      end else if (cmd_i.op == OP_ACCEPT && command_i == CMD_CLEAR) begin
        ccount_q <= '0;
      end
    end
  end

  // run control flags
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q   <= '0;
      err_q   <= 1'b0;
      olast_q <= 1'b0;
      oerr_q  <= 1'b0;
    end else begin
      case (cmd_i.op)
        OP_SETUP0: begin
          idx_q <= '0;
          err_q <= err_calc;
        end
        OP_F_WR, OP_S_ACC:
          idx_q <= is_last ? '0 : idx_q + 1'b1;
        OP_O_NEXT:
          idx_q <= idx_q + 1'b1;
        OP_O_LOAD: begin
          olast_q <= is_last;
          oerr_q  <= 1'b0;
        end
        OP_ERR_LOAD: begin
          olast_q <= 1'b1;
          oerr_q  <= 1'b1;
        end
        default: ;
      endcase
    end
  end

  // datapath registers
  always_ff @(posedge clk_i) begin
    case (cmd_i.op)
      OP_SETUP0: begin
        n_q     <= n_calc;
        mm_q    <= (n_calc > NW'(1)) ? IW'(n_calc - 1'b1) : IW'(1);
        kind_q  <= kind_calc;
        gauss_q <= (kind_calc == MODE_GAUSS) || (kind_calc == MODE_GREV) ||
                   (kind_calc == MODE_GSYM);
        rev_q   <= (kind_calc == MODE_GREV);
        cust_q  <= (kind_calc == MODE_CUST);
        total_q <= '0;
        if (kind_calc == MODE_GSYM) begin
          glo_q   <= -mag;
          ghi_q   <= mag;
          gmean_q <= '0;
        end else begin
          glo_q   <= blo_s;
          ghi_q   <= bhi_s;
          gmean_q <= {{2{mean_q[15]}}, mean_q};
        end
      end
      OP_SETUP1: begin
        s2_q    <= (spread_q == 15'd0) ? 30'd1 : 30'(spread_q) * 30'(spread_q);
        mm2_q   <= (2*IW)'(mm_q) * (2*IW)'(mm_q);
        diff0_q <= DW'(DW'($signed({glo_q[17], glo_q} - {gmean_q[17], gmean_q})) *
                       $signed({1'b0, DW'(mm_q)}));
        step_q  <= {ghi_q[17], ghi_q} - {glo_q[17], glo_q};
      end
      OP_SETUP2: begin
        den_q <= DENW'({DENW'(s2_q) * DENW'(mm2_q), 1'b0});
        d_q   <= diff0_q;
      end
      OP_F_SQ: begin
        sq_q   <= SW'(ad) * SW'(ad);
        cnum_q <= (IW+CW+4)'(idx_q) * (IW+CW+4)'(10 * 32'(ccount_q) - 1);
      end
      OP_F_DIV:
        sat_q <= (sq_q >= SW'({den_q, 4'd0}));
      OP_F_EXP:
        u_q <= uprod[33:16];
      OP_F_INT: begin
        v_q      <= pa - 17'(ipl >> 8);
        ip_q     <= u_q[16:12];
        picked_q <= cram_rdata;
      end
      OP_F_WR: begin
        d_q <= d_q + DW'(step_q);
        if (cust_q && (idx_q == '0 || picked_q < mn_q)) begin
          mn_q <= picked_q;
        end
      end
      OP_S_ACC:
        total_q <= total_q + TW'(reff);
      OP_O_LOAD: begin
        weight_q <= (total_q == '0) ? 16'd0 :
                    (div_quot[16] ? 16'hFFFF : div_quot[15:0]);
        pos_q    <= 6'(idx_q);
      end
      OP_ERR_LOAD: begin
        weight_q <= '0;
        pos_q    <= '0;
      end
      default: ;
    endcase
  end

  assign status_o.is_last  = is_last;
  assign status_o.err      = err_q;
  assign status_o.div_done = div_done;
  assign status_o.out_last = olast_q;

  assign weight_o   = weight_q;
  assign position_o = pos_q;
  assign last_o     = olast_q;
  assign error_o    = oerr_q;

endmodule

// ===== hw/rtl/bwtg_ctrl.sv =====
// Controller: sequences setup, fill, sum and output passes.
module bwtg_ctrl (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   in_valid_i,
  input  logic [1:0]             command_i,
  input  logic                   out_ready_i,
  input  bwtg_pkg::bwtg_status_t status_i,
  output bwtg_pkg::bwtg_cmd_t    cmd_o,
  output logic                   in_ready_o,
  output logic                   out_valid_o
);
  import bwtg_pkg::*;

  bwtg_state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // next state and datapath command
  always_comb begin
    state_d   = state_q;
    cmd_o.op  = OP_IDLE;
    case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          cmd_o.op = OP_ACCEPT;
          if (command_i == CMD_GEN) begin
            state_d = ST_SETUP0;
          end
        end
      end
      ST_SETUP0: begin
        cmd_o.op = OP_SETUP0;
        state_d  = ST_SETUP1;
      end
      ST_SETUP1: begin
        cmd_o.op = OP_SETUP1;
        state_d  = status_i.err ? ST_ERR : ST_SETUP2;
      end
      ST_SETUP2: begin
        cmd_o.op = OP_SETUP2;
        state_d  = ST_F_SQ;
      end
      ST_F_SQ: begin
        cmd_o.op = OP_F_SQ;
        state_d  = ST_F_DIV;
      end
      ST_F_DIV: begin
        cmd_o.op = OP_F_DIV;
        state_d  = ST_F_WAIT;
      end
      ST_F_WAIT: begin
        if (status_i.div_done) begin
          state_d = ST_F_EXP;
        end
      end
      ST_F_EXP: begin
        cmd_o.op = OP_F_EXP;
        state_d  = ST_F_INT;
      end
      ST_F_INT: begin
        cmd_o.op = OP_F_INT;
        state_d  = ST_F_WR;
      end
      ST_F_WR: begin
        cmd_o.op = OP_F_WR;
        state_d  = status_i.is_last ? ST_S_RD : ST_F_SQ;
      end
      ST_S_RD: begin
        cmd_o.op = OP_S_RD;
        state_d  = ST_S_ACC;
      end
      ST_S_ACC: begin
        cmd_o.op = OP_S_ACC;
        state_d  = status_i.is_last ? ST_O_RD : ST_S_RD;
      end
      ST_O_RD: begin
        cmd_o.op = OP_O_RD;
        state_d  = ST_O_DIV;
      end
      ST_O_DIV: begin
        cmd_o.op = OP_O_DIV;
        state_d  = ST_O_WAIT;
      end
      ST_O_WAIT: begin
        if (status_i.div_done) begin
          cmd_o.op = OP_O_LOAD;
          state_d  = ST_O_HOLD;
        end
      end
      ST_O_HOLD: begin
        if (out_ready_i) begin
          if (status_i.out_last) begin
            state_d = ST_IDLE;
          end else begin
            cmd_o.op = OP_O_NEXT;
            state_d  = ST_O_RD;
          end
        end
      end
      ST_ERR: begin
        cmd_o.op = OP_ERR_LOAD;
        state_d  = ST_O_HOLD;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  assign in_ready_o  = (state_q == ST_IDLE);
  assign out_valid_o = (state_q == ST_O_HOLD);

endmodule

// ===== hw/rtl/blend_weight_table_generator_unit.sv =====
// Top level of the blend weight table generator.
//
// Input stream: tuser carries the command (append custom weight, clear the
// custom list, generate table), tdata the signed Q8.8 custom weight.
// Append and clear are taken while idle. A generate command emits one result
// per table entry (Q0.16 weight and position in tdata, tlast on the final
// entry) or a single error result (tuser high, tlast high).
// Configuration registers are written through cfg_we_i/cfg_idx_i/cfg_data_i.
// Throughput: one item at a time. Generate runs setup, then a fill pass
// (waiting on the shared restoring divider for each entry), a sum pass and
// a normalize pass (again dominated by the divider).
// The input is not ready while a table is built or waits on the output.
// A stalled receiver holds the current result in the output register and
// the controller waits. Reset returns the controller to idle, restores the
// register defaults and empties the custom list.
module blend_weight_table_generator_unit #(
  parameter int unsigned MAX_FRAMES = 64,
  parameter int unsigned MAX_CUSTOM = 64
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [2:0]  cfg_idx_i,
  input  logic [15:0] cfg_data_i,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [15:0] s_axis_tdata,  // [15:0] custom_weight
  input  logic [1:0]  s_axis_tuser,  // [1:0] command
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [23:0] m_axis_tdata,  // [15:0] weight, [21:16] position, [23:22] zero
  output logic        m_axis_tlast,
  output logic        m_axis_tuser   // [0] error
);
  import bwtg_pkg::*;

  bwtg_cmd_t    cmd;
  bwtg_status_t status;
  logic [15:0]  weight;
  logic [5:0]   position;

  bwtg_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid),
    .command_i   (s_axis_tuser),
    .out_ready_i (m_axis_tready),
    .status_i    (status),
    .cmd_o       (cmd),
    .in_ready_o  (s_axis_tready),
    .out_valid_o (m_axis_tvalid)
  );

  bwtg_dp #(
    .MAX_FRAMES (MAX_FRAMES),
    .MAX_CUSTOM (MAX_CUSTOM)
  ) u_dp (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_we_i        (cfg_we_i),
    .cfg_idx_i       (cfg_idx_i),
    .cfg_data_i      (cfg_data_i),
    .command_i       (s_axis_tuser),
    .custom_weight_i (s_axis_tdata),
    .cmd_i           (cmd),
    .status_o        (status),
    .weight_o        (weight),
    .position_o      (position),
    .last_o          (m_axis_tlast),
    .error_o         (m_axis_tuser)
  );

  assign m_axis_tdata = {2'b00, position, weight};

endmodule

// ===== hw/rtl/bwtg_checker.sv =====
// Port-level checker for the blend weight table generator, bound to the top.
module bwtg_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        s_axis_tready,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [23:0] m_axis_tdata,
  input logic        m_axis_tlast,
  input logic        m_axis_tuser
);

  // a stalled result stays offered
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
    else $error("result dropped while stalled");

  // an error result closes its run with a zero weight
  a_err: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tuser |-> m_axis_tlast && (m_axis_tdata[15:0] == 16'd0))
    else $error("malformed error result");

  // no new input while a result waits
  a_excl: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(s_axis_tready && m_axis_tvalid))
    else $error("input ready while output pending");

  // after the final transfer the block goes idle
  a_end: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tready && m_axis_tlast |=> !m_axis_tvalid && s_axis_tready)
    else $error("block not idle after final result");

endmodule

bind blend_weight_table_generator_unit bwtg_checker u_bwtg_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tlast  (m_axis_tlast),
  .m_axis_tuser  (m_axis_tuser)
);

// ===== verif/tb_blend_weight_table_generator_unit.sv =====
// Self-checking testbench for the blend weight table generator unit.
module tb_blend_weight_table_generator_unit;
  import bwtg_pkg::*;

  typedef struct packed {
    logic [15:0] weight;
    logic [5:0]  position;
    logic        last;
    logic        error;
  } weight_entry_t;

  typedef struct {
    logic [1:0]  cmd;
    logic [15:0] custom;
    logic        has_fixed;
    logic [15:0] fixed_weight;
    logic        fixed_error;
  } stim_row_t;

  localparam int unsigned TIMEOUT_CYCLES = 4000000;
  // command code that the block ignores
  localparam logic [1:0]  CMD_NOP = 2'd3;

  logic        clk_i;
  logic        rst_ni;
  logic        cfg_we_i;
  logic [2:0]  cfg_idx_i;
  logic [15:0] cfg_data_i;
  logic        s_axis_tvalid;
  logic        s_axis_tready;
  logic [15:0] s_axis_tdata;   // [15:0] custom_weight
  logic [1:0]  s_axis_tuser;   // [1:0] command
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [23:0] m_axis_tdata;   // [15:0] weight, [21:16] position, [23:22] zero
  logic        m_axis_tlast;
  logic        m_axis_tuser;   // [0] error

  // Shadow of the block's configuration and custom list
  logic [3:0]  shd_mode;
  logic [6:0]  shd_frames;
  logic [15:0] shd_mean;
  logic [14:0] shd_spread;
  logic [15:0] shd_blow;
  logic [15:0] shd_bhigh;
  logic [15:0] shd_custom [64];
  int unsigned shd_count;

  weight_entry_t pending_weights[$];
  int unsigned   fail_count;
  int unsigned   cycle_count = 0;
  logic          rx_stall_mode = 1'b0;

  blend_weight_table_generator_unit u_dut (.*);

  // Clock
  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  // Watchdog
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > TIMEOUT_CYCLES) begin
      $display("FAILURE");
      $finish;
    end
  end

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    $display("mismatch %s: got %0d expected %0d at cycle %0d", what, got, want,
             cycle_count);
    fail_count++;
  endtask

  // exp(-sq/den) as 2^-x from the fraction table, Q30
  function automatic logic [31:0] neg_exp_q30(input logic [63:0] sq, input logic [63:0] den);
    logic [63:0] t12, u;
    logic [31:0] ip, fr, k, r, a, b, v;
    if (sq >= 64'd16 * den) t12 = 64'd65536;
    else t12 = (sq * 64'd4096) / den;
    u = (t12 * 64'd94548) >> 16;
    ip = u[43:12];
    fr = {20'd0, u[11:0]};
    k = fr >> 8;
    r = fr & 32'd255;
    a = pow2_frac(k[4:0]);
    b = pow2_frac(k[4:0] + 5'd1);
    v = a - (((a - b) * r) >> 8);
    if (ip > 31) return 32'd0;
    return 32'((64'(v) << 14) >> ip);
  endfunction

  function automatic logic gauss_raw(input int unsigned n, input longint mean,
                                     input longint lo, input longint hi,
                                     ref logic [31:0] raw [64]);
    longint mm, d;
    logic [63:0] s, den, ad;
    if (lo == hi) return 1'b0;
    s = shd_spread;
    if (s == 0) s = 1;
    mm = (n > 1) ? n - 1 : 1;
    den = 64'd2 * s * s * 64'(mm) * 64'(mm);
    for (int i = 0; i < n; i++) begin
      d = (lo - mean) * mm + longint'(i) * (hi - lo);
      ad = (d < 0) ? -d : d;
      raw[i] = neg_exp_q30(ad * ad, den);
    end
    return 1'b1;
  endfunction

  // Apply one accepted item to the shadow state and queue its weights
  task automatic predict_table(input logic [1:0] cmd, input logic [15:0] cw);
    logic [31:0] raw [64];
    longint picked [64];
    longint mn, a, b, m, pd;
    logic [63:0] total, w;
    int unsigned n, idx;
    logic ok, rev;
    weight_entry_t e;
    ok = 1'b1;
    rev = 1'b0;
    if (cmd == CMD_APPEND) begin
      if (shd_count < 64) begin
        shd_custom[shd_count] = cw;
        shd_count++;
      end
      return;
    end
    if (cmd == CMD_CLEAR) begin
      shd_count = 0;
      return;
    end
    if (cmd != CMD_GEN) return;
    n = shd_frames;
    if (n < 1) n = 1;
    if (n > 64) n = 64;
    case (shd_mode)
      MODE_ASC:   for (int i = 0; i < n; i++) raw[i] = i + 1;
      MODE_DESC:  for (int i = 0; i < n; i++) raw[i] = n - i;
      MODE_PYR: begin
        for (int i = 0; i < n; i++) begin
          pd = 2 * i - longint'(n - 1);
          raw[i] = 32'(longint'(n - 1) - (pd < 0 ? -pd : pd) + 2);
        end
      end
      MODE_GAUSS, MODE_GREV: begin
        ok = gauss_raw(n, longint'($signed(shd_mean)), longint'($signed(shd_blow)),
                       longint'($signed(shd_bhigh)), raw);
        rev = (shd_mode == MODE_GREV);
      end
      MODE_GSYM: begin
        a = longint'($signed(shd_blow));
        b = longint'($signed(shd_bhigh));
        if (a < 0) a = -a;
        if (b < 0) b = -b;
        m = (a > b) ? a : b;
        ok = gauss_raw(n, 0, -m, m, raw);
      end
      MODE_VEGAS: begin
        for (int i = 0; i < n; i++)
          raw[i] = (n % 2 == 0 && i != 0 && i != n - 1) ? 2 : 1;
      end
      MODE_CUST: begin
        if (shd_count == 0) ok = 1'b0;
        else begin
          mn = 0;
          for (int i = 0; i < n; i++) begin
            idx = 0;
            if (n > 1) idx = (i * (10 * shd_count - 1)) / (10 * (n - 1));
            if (idx >= shd_count) idx = shd_count - 1;
            picked[i] = longint'($signed(shd_custom[idx]));
            if (i == 0 || picked[i] < mn) mn = picked[i];
          end
          for (int i = 0; i < n; i++)
            raw[i] = 32'((mn < 0) ? picked[i] - mn + 256 : picked[i]);
        end
      end
      default: for (int i = 0; i < n; i++) raw[i] = 1;
    endcase
    if (!ok) begin
      e = '{weight: 16'd0, position: 6'd0, last: 1'b1, error: 1'b1};
      pending_weights = {pending_weights, e};
      return;
    end
    total = 0;
    for (int i = 0; i < n; i++) total += raw[i];
    for (int i = 0; i < n; i++) begin
      w = (total != 0) ? (64'(raw[rev ? n - 1 - i : i]) << 16) / total : 0;
      if (w > 65535) w = 65535;
      e = '{weight: w[15:0], position: i[5:0], last: (i == n - 1), error: 1'b0};
      pending_weights = {pending_weights, e};
    end
  endtask

  // Check each transfer on the output against the oldest expectation
  always @(posedge clk_i) begin
    weight_entry_t e;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (pending_weights.size() == 0) begin
        report_mismatch("unexpected result", m_axis_tdata, 0);
      end else begin
        e = pending_weights.pop_front();
        if (m_axis_tdata[15:0] !== e.weight) report_mismatch("weight", m_axis_tdata[15:0], e.weight);
        if (m_axis_tdata[21:16] !== e.position)
          report_mismatch("position", m_axis_tdata[21:16], e.position);
        if (m_axis_tdata[23:22] !== 2'd0) report_mismatch("pad", m_axis_tdata[23:22], 0);
        if (m_axis_tlast !== e.last) report_mismatch("last", m_axis_tlast, e.last);
        if (m_axis_tuser !== e.error) report_mismatch("error", m_axis_tuser, e.error);
      end
    end
  end

  // Receiver stall pattern: runs of free flow and runs of random stalls
  always @(posedge clk_i) begin
    if (($urandom % 64) == 0) rx_stall_mode <= ~rx_stall_mode;
    m_axis_tready <= rx_stall_mode ? ($urandom_range(0, 3) == 0) : 1'b1;
  end

  // Write one register, then drop the write enable again
  task automatic write_reg(input logic [2:0] idx, input logic [15:0] val);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= val;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    @(posedge clk_i);
    case (idx)
      CFG_MODE:   shd_mode   = val[3:0];
      CFG_FRAMES: shd_frames = val[6:0];
      CFG_MEAN:   shd_mean   = val;
      CFG_SPREAD: shd_spread = val[14:0];
      CFG_BLOW:   shd_blow   = val;
      CFG_BHIGH:  shd_bhigh  = val;
      default: ;
    endcase
  endtask

  // Wait for all results, then let the block settle before a write
  task automatic drain_results();
    while (pending_weights.size() != 0) @(posedge clk_i);
    repeat (200) @(posedge clk_i);
  endtask

  // Send one item; with hold set, tvalid stays high across back-to-back transfers
  task automatic send_item(input logic [1:0] cmd, input logic [15:0] cw, input logic hold);
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= cmd;
    s_axis_tdata  <= cw;
    do @(posedge clk_i); while (!s_axis_tready);
    predict_table(cmd, cw);
    if (!hold) s_axis_tvalid <= 1'b0;
  endtask

  // Random gaussian, custom and shape setup between phases
  task automatic random_config();
    write_reg(CFG_MODE, 16'($urandom_range(0, 15)));
    write_reg(CFG_FRAMES, ($urandom_range(0, 7) == 0) ? 16'($urandom_range(0, 127))
                                                      : 16'($urandom_range(1, 12)));
    write_reg(CFG_MEAN, 16'($urandom));
    write_reg(CFG_SPREAD, ($urandom_range(0, 1)) ? 16'($urandom_range(0, 32767))
                                                 : 16'($urandom_range(0, 1024)));
    write_reg(CFG_BLOW, 16'($urandom));
    write_reg(CFG_BHIGH, ($urandom_range(0, 9) == 0) ? shd_blow : 16'($urandom));
  endtask

  stim_row_t directed [$];
  logic [15:0] wv;
  int unsigned burst;

  initial begin
    rst_ni = 1'b0;
    cfg_we_i = 1'b0;
    cfg_idx_i = CFG_MODE;
    cfg_data_i = '0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata = '0;
    s_axis_tuser = CMD_APPEND;
    fail_count = 0;
    shd_mode = MODE_EQUAL;
    shd_frames = RST_FRAMES;
    shd_mean = '0;
    shd_spread = RST_SPREAD;
    shd_blow = RST_BLOW;
    shd_bhigh = RST_BHIGH;
    shd_count = 0;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Generate with reset settings, then an empty custom list (error result)
    send_item(CMD_GEN, 16'h0000, 1'b0);
    drain_results();
    write_reg(CFG_MODE, MODE_CUST);
    write_reg(CFG_FRAMES, 16'd1);
    directed = '{
      '{CMD_GEN,    16'h0000, 1'b1, 16'd0, 1'b1},
      '{CMD_APPEND, 16'h8000, 1'b0, 16'd0, 1'b0},
      '{CMD_APPEND, 16'h7FFF, 1'b0, 16'd0, 1'b0},
      '{CMD_APPEND, 16'hFFFF, 1'b0, 16'd0, 1'b0},
      '{CMD_GEN,    16'h0000, 1'b1, 16'd65535, 1'b0},
      '{CMD_NOP,    16'hFFFF, 1'b0, 16'd0, 1'b0},
      '{CMD_CLEAR,  16'h0000, 1'b0, 16'd0, 1'b0},
      '{CMD_GEN,    16'h0000, 1'b1, 16'd0, 1'b1},
      '{CMD_APPEND, 16'h0000, 1'b0, 16'd0, 1'b0},
      '{CMD_GEN,    16'h0000, 1'b1, 16'd0, 1'b0}
    };
    foreach (directed[i]) begin
      send_item(directed[i].cmd, directed[i].custom, 1'b0);
      if (directed[i].has_fixed && pending_weights.size() != 0 &&
          (pending_weights[pending_weights.size() - 1].weight !== directed[i].fixed_weight ||
           pending_weights[pending_weights.size() - 1].error !== directed[i].fixed_error))
        report_mismatch("directed row", i, 0);
      drain_results();
    end

    // Every mode at the frame-count extremes; fill the custom list past full
    for (int k = 0; k < 66; k++) send_item(CMD_APPEND, 16'($urandom), 1'b1);
    s_axis_tvalid <= 1'b0;
    for (int md = 0; md < 16; md += ((md < 8) ? 1 : 7)) begin
      write_reg(CFG_MODE, 16'(md));
      write_reg(CFG_FRAMES, (md % 2) ? 16'd127 : 16'd0);
      write_reg(CFG_MEAN, (md % 3 == 0) ? 16'h8000 : 16'h7FFF);
      write_reg(CFG_SPREAD, (md % 2) ? 16'h7FFF : 16'd0);
      write_reg(CFG_BLOW, (md == 6) ? 16'd0 : 16'h8000);
      write_reg(CFG_BHIGH, (md == 6) ? 16'd0 : 16'h7FFF);
      send_item(CMD_GEN, 16'h0000, 1'b0);
      drain_results();
    end
    write_reg(CFG_BLOW, 16'h0100);
    write_reg(CFG_BHIGH, 16'h0100);
    write_reg(CFG_MODE, MODE_GAUSS);
    send_item(CMD_GEN, 16'h0000, 1'b0);
    drain_results();

    // Random phases: custom sequences followed by generates, with noise
    for (int ph = 0; ph < 10; ph++) begin
      random_config();
      burst = $urandom_range(1, 4);
      for (int k = 0; k < 8; k++) begin
        if ($urandom_range(0, 9) == 0) send_item(CMD_CLEAR, 16'($urandom), 1'b1);
        else if ($urandom_range(0, 19) == 0) send_item(CMD_NOP, 16'($urandom), 1'b1);
        else if (k == 7 || $urandom_range(0, 4) == 0) send_item(CMD_GEN, 16'($urandom), 1'b1);
        else begin
          wv = ($urandom_range(0, 2) == 0) ? 16'($signed($urandom_range(0, 600)) - 300)
                                           : 16'($urandom);
          send_item(CMD_APPEND, wv, 1'b1);
        end
        if (burst > 1) burst--;
        else begin
          s_axis_tvalid <= 1'b0;
          repeat ($urandom_range(1, 6)) @(posedge clk_i);
          burst = $urandom_range(1, 4);
        end
      end
      s_axis_tvalid <= 1'b0;
      drain_results();
    end

    drain_results();
    if (fail_count == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
